@@ design/spc_pkg.sv @@
// Package for the sphere pair contact pipeline: widths, register codes,
// reset values and the carry structures that travel with the iterative units.
// No dependencies.
package spc_pkg;

    localparam int COORD_BITS  = 21;
    localparam int PACK_W      = 3 * COORD_BITS;
    localparam int DELTA_W     = COORD_BITS + 1;
    localparam int MAG_W       = COORD_BITS;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SUMSQ_W     = SQ_W + 2;
    localparam int ROOT_W      = SUMSQ_W / 2;
    localparam int SQRT_W      = SUMSQ_W + 1;
    localparam int RAD_W       = 20;
    localparam int RADSUM_W    = RAD_W + 1;
    localparam int THR_W       = RAD_W + 2;
    localparam int NORM_W      = 16;
    localparam int NORM_FRAC   = 14;
    localparam int QUO_W       = NORM_FRAC + 1;
    localparam int NUM_W       = MAG_W + NORM_FRAC + 1;
    localparam int DEPTH_W     = 22;
    localparam int DEPTH_INT_W = ROOT_W + 1;
    localparam int SCALE_W     = DEPTH_INT_W + 2;
    localparam int TAG_W       = 16;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 3 * NORM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK  = 2'd2;

    localparam logic [RAD_W-1:0]      TOLERANCE_RST = '0;
    localparam logic [RAD_W-1:0]      MIN_DIST_RST  = RAD_W'(1);
    localparam logic [3*NORM_W-1:0]   FALLBACK_RST  = 48'd49152;

    // Carry through the square root unit.
    typedef struct packed {
        logic [2:0][DELTA_W-1:0]    od;
        logic [RADSUM_W-1:0]        radsum;
        logic [RAD_W-1:0]           orb;
        logic [2:0][COORD_BITS-1:0] ob;
        logic [2:0][COORD_BITS-1:0] pa;
        logic [2:0][COORD_BITS-1:0] pb;
        logic [TAG_W-1:0]           tag;
    } sq_side_t;

    // Carry through the divider.
    typedef struct packed {
        logic [2:0]                 neg;
        logic                       use_fb;
        logic [DEPTH_INT_W-1:0]     depth;
        logic [SCALE_W-1:0]         scale;
        logic [2:0][COORD_BITS-1:0] ob;
        logic [2:0][COORD_BITS-1:0] pa;
        logic [2:0][COORD_BITS-1:0] pb;
        logic [TAG_W-1:0]           tag;
    } dv_side_t;

endpackage

@@ design/spc_if.sv @@
// Valid/ready channel interfaces for the sphere pair contact block:
// pair input, contact output and configuration write. Depends on spc_pkg.
interface spc_in_if import spc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PACK_W-1:0]    old_center_a;
    logic [PACK_W-1:0]    new_center_a;
    logic [PACK_W-1:0]    old_center_b;
    logic [PACK_W-1:0]    new_center_b;
    logic [RAD_W-1:0]     new_radius_a;
    logic [RAD_W-1:0]     new_radius_b;
    logic [RAD_W-1:0]     old_radius_b;
    logic [PACK_W-1:0]    body_pos_a;
    logic [PACK_W-1:0]    body_pos_b;
    logic [TAG_W-1:0]     pair_tag;

    modport source (output valid, old_center_a, new_center_a, old_center_b, new_center_b,
                    new_radius_a, new_radius_b, old_radius_b, body_pos_a, body_pos_b,
                    pair_tag, input ready);
    modport sink (input valid, old_center_a, new_center_a, old_center_b, new_center_b,
                  new_radius_a, new_radius_b, old_radius_b, body_pos_a, body_pos_b,
                  pair_tag, output ready);
endinterface

interface spc_out_if import spc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [3*NORM_W-1:0]   contact_normal;
    logic [PACK_W-1:0]     contact_rel_a;
    logic [PACK_W-1:0]     contact_rel_b;
    logic [DEPTH_W-1:0]    depth;
    logic [TAG_W-1:0]      result_tag;

    modport source (output valid, contact_normal, contact_rel_a, contact_rel_b, depth,
                    result_tag, input ready);
    modport sink (input valid, contact_normal, contact_rel_a, contact_rel_b, depth,
                  result_tag, output ready);
endinterface

interface spc_cfg_if import spc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/spc_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage, with a carry
// structure riding along. Depends on spc_pkg.
module spc_sqrt_pipe import spc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SUMSQ_W-1:0]   in_rad,
    input  sq_side_t             in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ROOT_W-1:0]    out_root,
    output sq_side_t             out_side
);

    localparam int NS = ROOT_W;

    logic              v_reg    [NS];
    logic [SQRT_W-1:0] rem_reg  [NS];
    logic [SQRT_W-1:0] res_reg  [NS];
    sq_side_t          side_reg [NS];
    logic [NS-1:0]     en;

    // A stage may load when it is empty or its successor loads too.
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic              v_in;
        logic [SQRT_W-1:0] rem_in;
        logic [SQRT_W-1:0] res_in;
        sq_side_t          side_in;
        logic [SQRT_W-1:0] bit_val;
        logic [SQRT_W-1:0] trial;
        logic [SQRT_W-1:0] rem_next;
        logic [SQRT_W-1:0] res_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = SQRT_W'(in_rad);
            assign res_in  = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign bit_val = SQRT_W'(1) << (2 * (NS - 1 - k));

        always_comb
        begin
            trial = res_in + bit_val;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + bit_val;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rem_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_root  = res_reg[NS-1][ROOT_W-1:0];
    assign out_side  = side_reg[NS-1];

endmodule

@@ design/spc_div_pipe.sv @@
// Three-lane pipelined restoring divider, one quotient bit per stage, sharing
// the divisor across lanes. Depends on spc_pkg.
module spc_div_pipe import spc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0][NUM_W-1:0]    in_num,
    input  logic [ROOT_W-1:0]        in_dist,
    input  dv_side_t                 in_side,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0][QUO_W-1:0]    out_quo,
    output dv_side_t                 out_side
);

    localparam int NS = QUO_W;

    logic                  v_reg    [NS];
    logic [2:0][NUM_W-1:0] rem_reg  [NS];
    logic [2:0][QUO_W-1:0] quo_reg  [NS];
    logic [ROOT_W-1:0]     dist_reg [NS];
    dv_side_t              side_reg [NS];
    logic [NS-1:0]         en;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic                  v_in;
        logic [2:0][NUM_W-1:0] rem_in;
        logic [2:0][QUO_W-1:0] quo_in;
        logic [ROOT_W-1:0]     dist_in;
        dv_side_t              side_in;
        logic [NUM_W-1:0]      trial;
        logic [2:0][NUM_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_num;
            assign quo_in  = '0;
            assign dist_in = in_dist;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign dist_in = dist_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = NUM_W'(dist_in) << (NS - 1 - k);

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i] = rem_in[i];
                quo_next[i] = quo_in[i];
                if (rem_in[i] >= trial)
                begin
                    rem_next[i]             = rem_in[i] - trial;
                    quo_next[i][NS - 1 - k] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                dist_reg[k] <= dist_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

@@ design/sphere_pair_contact.sv @@
// Sphere pair contact test, one pair per beat, 47 register stages deep.
// Throughput: one beat per cycle while the receiver takes every result beat;
// contact_out.ready low stalls the pipe. The square root has 22 stages and
// the divider 15. Pairs without contact leave no output beat.
// Reset (rst_n low, asynchronous) empties every stage and loads the registers
// with tolerance 0, min distance 1 and fallback normal (0,0,-1).
// Depends on spc_pkg, spc_if, spc_sqrt_pipe and spc_div_pipe.
module sphere_pair_contact import spc_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    spc_in_if.sink          pair_in,
    spc_out_if.source       contact_out,
    spc_cfg_if.sink         cfg
);

    localparam int PROD_W = SCALE_W + NORM_W;
    localparam int RND_W  = PROD_W - NORM_FRAC;
    localparam int WP_W   = RND_W + 1;
    localparam int REL_W  = WP_W + 1;

    typedef struct packed {
        logic [3*NORM_W-1:0]        normal;
        logic [DEPTH_INT_W-1:0]     depth;
        logic [2:0][COORD_BITS-1:0] ob;
        logic [2:0][COORD_BITS-1:0] pa;
        logic [2:0][COORD_BITS-1:0] pb;
        logic [TAG_W-1:0]           tag;
    } tail_t;

    // Saturate a wide signed value to the coordinate range.
    function automatic logic [COORD_BITS-1:0] sat_coord(input logic [REL_W-1:0] v);
        logic [REL_W-COORD_BITS:0] top;
        logic [COORD_BITS-1:0]     res;
        top = v[REL_W-1:COORD_BITS-1];
        if (top == '0 || top == '1)
        begin
            res = v[COORD_BITS-1:0];
        end
        else
        begin
            res = {v[REL_W-1], {(COORD_BITS-1){!v[REL_W-1]}}};
        end
        return res;
    endfunction

    // Configuration registers. Writes must only happen while the pipe is idle;
    // the block itself does not enforce this. Later stages read them directly.
    logic [RAD_W-1:0]    tol_reg;
    logic [RAD_W-1:0]    min_dist_reg;
    logic [3*NORM_W-1:0] fb_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg      <= TOLERANCE_RST;
            min_dist_reg <= MIN_DIST_RST;
            fb_reg       <= FALLBACK_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TOLERANCE: tol_reg      <= cfg.data[RAD_W-1:0];
                CFG_MIN_DIST:  min_dist_reg <= cfg.data[RAD_W-1:0];
                CFG_FALLBACK:  fb_reg       <= cfg.data;
                default:       ;
            endcase
        end
    end

    // Stage valids and the backward load enables. Each stage loads when it
    // is empty or when the stage after it loads, so bubbles are squeezed out.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v6_reg, v7_reg, v8_reg, v9_reg, v10_reg;
    logic en1, en2, en3, en4, en5, en6, en7, en8, en9, en10;
    logic sqrt_in_ready, sqrt_out_valid, div_in_ready, div_out_valid;

    assign en10 = !v10_reg || contact_out.ready;
    assign en9  = !v9_reg || en10;
    assign en8  = !v8_reg || en9;
    assign en7  = !v7_reg || en8;
    assign en6  = !v6_reg || en7;
    assign en5  = !v5_reg || div_in_ready;
    assign en4  = !v4_reg || sqrt_in_ready;
    assign en3  = !v3_reg || en4;
    assign en2  = !v2_reg || en3;
    assign en1  = !v1_reg || en2;

    assign pair_in.ready = en1;

    // Stage 1: center deltas, radius sum and contact threshold.
    sq_side_t                side1_reg;
    logic [2:0][DELTA_W-1:0] nd1_reg;
    logic [THR_W-1:0]        thr1_reg;
    sq_side_t                side1_next;
    logic [2:0][DELTA_W-1:0] nd1_next;

    always_comb
    begin
        side1_next.radsum = RADSUM_W'(pair_in.new_radius_a) + RADSUM_W'(pair_in.new_radius_b);
        side1_next.orb    = pair_in.old_radius_b;
        side1_next.ob     = pair_in.old_center_b;
        side1_next.pa     = pair_in.body_pos_a;
        side1_next.pb     = pair_in.body_pos_b;
        side1_next.tag    = pair_in.pair_tag;
        for (int i = 0; i < 3; i++)
        begin
            side1_next.od[i] =
                {pair_in.old_center_a[i*COORD_BITS + COORD_BITS - 1],
                 pair_in.old_center_a[i*COORD_BITS +: COORD_BITS]} -
                {pair_in.old_center_b[i*COORD_BITS + COORD_BITS - 1],
                 pair_in.old_center_b[i*COORD_BITS +: COORD_BITS]};
            nd1_next[i] =
                {pair_in.new_center_a[i*COORD_BITS + COORD_BITS - 1],
                 pair_in.new_center_a[i*COORD_BITS +: COORD_BITS]} -
                {pair_in.new_center_b[i*COORD_BITS + COORD_BITS - 1],
                 pair_in.new_center_b[i*COORD_BITS +: COORD_BITS]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            side1_reg <= side1_next;
            nd1_reg   <= nd1_next;
            thr1_reg  <= THR_W'(side1_next.radsum) + THR_W'(tol_reg);
        end
    end

    // Stage 2: squares of the delta components and of the threshold.
    sq_side_t             side2_reg;
    logic [2:0][SQ_W-1:0] osq2_reg;
    logic [2:0][SQ_W-1:0] nsq2_reg;
    logic [SUMSQ_W-1:0]   thrsq2_reg;
    logic [2:0][SQ_W-1:0] osq2_next;
    logic [2:0][SQ_W-1:0] nsq2_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [DELTA_W-1:0] om;
            logic [DELTA_W-1:0] nm;
            om = side1_reg.od[i][DELTA_W-1] ? -side1_reg.od[i] : side1_reg.od[i];
            nm = nd1_reg[i][DELTA_W-1] ? -nd1_reg[i] : nd1_reg[i];
            osq2_next[i] = SQ_W'(om[MAG_W-1:0]) * SQ_W'(om[MAG_W-1:0]);
            nsq2_next[i] = SQ_W'(nm[MAG_W-1:0]) * SQ_W'(nm[MAG_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            side2_reg  <= side1_reg;
            osq2_reg   <= osq2_next;
            nsq2_reg   <= nsq2_next;
            thrsq2_reg <= SUMSQ_W'(thr1_reg) * SUMSQ_W'(thr1_reg);
        end
    end

    // Stage 3: squared distances.
    sq_side_t           side3_reg;
    logic [SUMSQ_W-1:0] odsq3_reg;
    logic [SUMSQ_W-1:0] ndsq3_reg;
    logic [SUMSQ_W-1:0] thrsq3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            side3_reg  <= side2_reg;
            odsq3_reg  <= SUMSQ_W'(osq2_reg[0]) + SUMSQ_W'(osq2_reg[1]) +
                          SUMSQ_W'(osq2_reg[2]);
            ndsq3_reg  <= SUMSQ_W'(nsq2_reg[0]) + SUMSQ_W'(nsq2_reg[1]) +
                          SUMSQ_W'(nsq2_reg[2]);
            thrsq3_reg <= thrsq2_reg;
        end
    end

    // Stage 4: contact decision. A pair without contact is dropped here by
    // clearing its valid bit.
    sq_side_t           side4_reg;
    logic [SUMSQ_W-1:0] odsq4_reg;
    logic [SUMSQ_W-1:0] dmin3;
    logic               hit3;

    assign dmin3 = (odsq3_reg < ndsq3_reg) ? odsq3_reg : ndsq3_reg;
    assign hit3  = dmin3 < thrsq3_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            side4_reg <= side3_reg;
            odsq4_reg <= odsq3_reg;
        end
    end

    // Old center distance.
    logic [ROOT_W-1:0] sqrt_root;
    sq_side_t          sqrt_side;

    spc_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_ready  (sqrt_in_ready),
        .in_rad    (odsq4_reg),
        .in_side   (side4_reg),
        .out_valid (sqrt_out_valid),
        .out_ready (en5),
        .out_root  (sqrt_root),
        .out_side  (sqrt_side)
    );

    // Stage 5: depth, fallback choice, offset length and divider numerators.
    // The offset length 2*old_radius_b - depth is kept in one more fraction bit.
    dv_side_t              side5_reg;
    logic [2:0][NUM_W-1:0] num5_reg;
    logic [ROOT_W-1:0]     dist5_reg;
    dv_side_t              side5_next;
    logic [2:0][NUM_W-1:0] num5_next;

    always_comb
    begin
        side5_next.depth  = DEPTH_INT_W'(sqrt_side.radsum) - DEPTH_INT_W'(sqrt_root);
        side5_next.use_fb = (sqrt_root <= ROOT_W'(min_dist_reg)) || (sqrt_root == '0);
        side5_next.scale  = SCALE_W'({sqrt_side.orb, 1'b0}) -
                            {{(SCALE_W-DEPTH_INT_W){side5_next.depth[DEPTH_INT_W-1]}},
                             side5_next.depth};
        side5_next.ob     = sqrt_side.ob;
        side5_next.pa     = sqrt_side.pa;
        side5_next.pb     = sqrt_side.pb;
        side5_next.tag    = sqrt_side.tag;
        for (int i = 0; i < 3; i++)
        begin
            logic [DELTA_W-1:0] m;
            side5_next.neg[i] = sqrt_side.od[i][DELTA_W-1];
            m = side5_next.neg[i] ? -sqrt_side.od[i] : sqrt_side.od[i];
            num5_next[i] = {1'b0, m[MAG_W-1:0], {NORM_FRAC{1'b0}}} +
                           NUM_W'(sqrt_root[ROOT_W-1:1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            side5_reg <= side5_next;
            num5_reg  <= num5_next;
            dist5_reg <= sqrt_root;
        end
    end

    // Normal components: rounded quotient of delta over distance. Since each
    // delta component is no longer than the distance, the quotient never
    // exceeds one in Q1.14 and needs no clamp.
    logic [2:0][QUO_W-1:0] div_quo;
    dv_side_t              div_side;

    spc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_ready  (div_in_ready),
        .in_num    (num5_reg),
        .in_dist   (dist5_reg),
        .in_side   (side5_reg),
        .out_valid (div_out_valid),
        .out_ready (en6),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // Stage 6: signed normal, or the fallback normal for a distance of zero or at or below the minimum distance.
    tail_t                  tail6_reg;
    logic [2:0][NORM_W-1:0] nrm6_reg;
    logic [SCALE_W-1:0]     scale6_reg;
    logic [2:0][NORM_W-1:0] nrm6_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (div_side.use_fb)
            begin
                nrm6_next[i] = fb_reg[i*NORM_W +: NORM_W];
            end
            else if (div_side.neg[i])
            begin
                nrm6_next[i] = -{1'b0, div_quo[i]};
            end
            else
            begin
                nrm6_next[i] = {1'b0, div_quo[i]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            nrm6_reg         <= nrm6_next;
            scale6_reg       <= div_side.scale;
            tail6_reg.normal <= nrm6_next;
            tail6_reg.depth  <= div_side.depth;
            tail6_reg.ob     <= div_side.ob;
            tail6_reg.pa     <= div_side.pa;
            tail6_reg.pb     <= div_side.pb;
            tail6_reg.tag    <= div_side.tag;
        end
    end

    // Stage 7: offset length times normal.
    tail_t                  tail7_reg;
    logic [2:0][PROD_W-1:0] prod7_reg;

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            tail7_reg <= tail6_reg;
            for (int i = 0; i < 3; i++)
            begin
                prod7_reg[i] <= $signed(scale6_reg) * $signed(nrm6_reg[i]);
            end
        end
    end

    // Stage 8: drop the product's fraction bits, rounding halves away from zero.
    tail_t                 tail8_reg;
    logic [2:0][RND_W-1:0] rnd8_reg;
    logic [2:0][RND_W-1:0] rnd8_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [PROD_W-1:0] mag;
            logic [PROD_W-1:0] sum;
            mag = prod7_reg[i][PROD_W-1] ? -prod7_reg[i] : prod7_reg[i];
            sum = mag + (PROD_W'(1) << NORM_FRAC);
            rnd8_next[i] = {1'b0, sum[PROD_W-1:NORM_FRAC+1]};
            if (prod7_reg[i][PROD_W-1])
            begin
                rnd8_next[i] = -rnd8_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en8)
        begin
            tail8_reg <= tail7_reg;
            rnd8_reg  <= rnd8_next;
        end
    end

    // Stage 9: world contact point.
    tail_t                wp_tail9_reg;
    logic [2:0][WP_W-1:0] wp9_reg;

    always_ff @(posedge clk)
    begin
        if (en9)
        begin
            wp_tail9_reg <= tail8_reg;
            for (int i = 0; i < 3; i++)
            begin
                wp9_reg[i] <= {{(WP_W-COORD_BITS){tail8_reg.ob[i][COORD_BITS-1]}},
                               tail8_reg.ob[i]} +
                              {rnd8_reg[i][RND_W-1], rnd8_reg[i]};
            end
        end
    end

    // Stage 10: output register with body-relative points and saturation.
    logic [3*NORM_W-1:0]        normal10_reg;
    logic [2:0][COORD_BITS-1:0] rel_a10_reg;
    logic [2:0][COORD_BITS-1:0] rel_b10_reg;
    logic [DEPTH_W-1:0]         depth10_reg;
    logic [TAG_W-1:0]           tag10_reg;
    logic [2:0][COORD_BITS-1:0] rel_a10_next;
    logic [2:0][COORD_BITS-1:0] rel_b10_next;
    logic [DEPTH_W-1:0]         depth10_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [REL_W-1:0] wpx;
            logic [REL_W-1:0] ra;
            logic [REL_W-1:0] rb;
            wpx = {wp9_reg[i][WP_W-1], wp9_reg[i]};
            ra  = wpx - {{(REL_W-COORD_BITS){wp_tail9_reg.pa[i][COORD_BITS-1]}},
                         wp_tail9_reg.pa[i]};
            rb  = wpx - {{(REL_W-COORD_BITS){wp_tail9_reg.pb[i][COORD_BITS-1]}},
                         wp_tail9_reg.pb[i]};
            rel_a10_next[i] = sat_coord(ra);
            rel_b10_next[i] = sat_coord(rb);
        end
        if (wp_tail9_reg.depth[DEPTH_INT_W-1] == wp_tail9_reg.depth[DEPTH_INT_W-2])
        begin
            depth10_next = wp_tail9_reg.depth[DEPTH_W-1:0];
        end
        else
        begin
            depth10_next = {wp_tail9_reg.depth[DEPTH_INT_W-1],
                            {(DEPTH_W-1){!wp_tail9_reg.depth[DEPTH_INT_W-1]}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en10)
        begin
            normal10_reg <= wp_tail9_reg.normal;
            rel_a10_reg  <= rel_a10_next;
            rel_b10_reg  <= rel_b10_next;
            depth10_reg  <= depth10_next;
            tag10_reg    <= wp_tail9_reg.tag;
        end
    end

    // Valid bits for the stages kept in this module.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= pair_in.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg && hit3;
            end
            if (en5)
            begin
                v5_reg <= sqrt_out_valid;
            end
            if (en6)
            begin
                v6_reg <= div_out_valid;
            end
            if (en7)
            begin
                v7_reg <= v6_reg;
            end
            if (en8)
            begin
                v8_reg <= v7_reg;
            end
            if (en9)
            begin
                v9_reg <= v8_reg;
            end
            if (en10)
            begin
                v10_reg <= v9_reg;
            end
        end
    end

    assign contact_out.valid          = v10_reg;
    assign contact_out.contact_normal = normal10_reg;
    assign contact_out.contact_rel_a  = rel_a10_reg;
    assign contact_out.contact_rel_b  = rel_b10_reg;
    assign contact_out.depth          = depth10_reg;
    assign contact_out.result_tag     = tag10_reg;

endmodule

@@ design/spc_checker.sv @@
// Port-level checks for the sphere pair contact block and the bind that
// attaches them to the top level. Depends on spc_pkg and sphere_pair_contact.
module spc_checker import spc_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [3*NORM_W-1:0] out_normal,
    input logic [PACK_W-1:0]   out_rel_a,
    input logic [PACK_W-1:0]   out_rel_b,
    input logic [DEPTH_W-1:0]  out_depth,
    input logic [TAG_W-1:0]    out_tag,
    input logic                cfg_valid,
    input logic                cfg_ready
);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
        $stable({out_normal, out_rel_a, out_rel_b, out_depth, out_tag}))
        else $error("result beat changed while stalled");

    // When the output side is free, the whole pipe moves and input is taken.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input held back while the output side is free");

    // Register writes are never refused.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind sphere_pair_contact spc_checker u_spc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (pair_in.ready),
    .out_valid  (contact_out.valid),
    .out_ready  (contact_out.ready),
    .out_normal (contact_out.contact_normal),
    .out_rel_a  (contact_out.contact_rel_a),
    .out_rel_b  (contact_out.contact_rel_b),
    .out_depth  (contact_out.depth),
    .out_tag    (contact_out.result_tag),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for sphere_pair_contact: random and directed sphere pairs,
// register writes between phases, a contact predictor and an in-order result check.
// Depends on spc_pkg, the channel interfaces in spc_if and sphere_pair_contact.

module tb_top;
    import spc_pkg::*;

    // Cycles with no beat on any channel before the run is declared hung.
    localparam int HANG_LIMIT  = 5000;
    // Cycles to let the pipeline empty of pairs that make no contact.
    localparam int DRAIN_WAIT  = 80;
    localparam int PHASE_ITEMS = 285;

    typedef struct {
        logic [PACK_W-1:0] old_center_a;
        logic [PACK_W-1:0] new_center_a;
        logic [PACK_W-1:0] old_center_b;
        logic [PACK_W-1:0] new_center_b;
        logic [RAD_W-1:0]  new_radius_a;
        logic [RAD_W-1:0]  new_radius_b;
        logic [RAD_W-1:0]  old_radius_b;
        logic [PACK_W-1:0] body_pos_a;
        logic [PACK_W-1:0] body_pos_b;
        logic [TAG_W-1:0]  pair_tag;
    } pair_t;

    typedef struct {
        logic [3*NORM_W-1:0] contact_normal;
        logic [PACK_W-1:0]   contact_rel_a;
        logic [PACK_W-1:0]   contact_rel_b;
        logic [DEPTH_W-1:0]  depth;
        logic [TAG_W-1:0]    result_tag;
    } contact_t;

    // Holds the register copy, computes the contact each pair should give
    // and keeps those contacts in order until the block delivers them.
    class contact_board;
        longint          tol_q;
        longint          min_dist_q;
        logic [47:0]     fb_normal;
        contact_t        pending[$];
        int              mismatches;
        int              pairs_seen;
        int              contacts_seen;
        int              fallback_used;
        int              reg_writes;

        function new();
            tol_q         = TOLERANCE_RST;
            min_dist_q    = MIN_DIST_RST;
            fb_normal     = FALLBACK_RST;
            mismatches    = 0;
            pairs_seen    = 0;
            contacts_seen = 0;
            fallback_used = 0;
            reg_writes    = 0;
        endfunction

        function void note_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            case (idx)
                CFG_TOLERANCE: tol_q      = data[RAD_W-1:0];
                CFG_MIN_DIST:  min_dist_q = data[RAD_W-1:0];
                CFG_FALLBACK:  fb_normal  = data[3*NORM_W-1:0];
                default: ;
            endcase
        endfunction

        // Slot 2 is x (high third), slot 0 is z.
        static function longint coord(logic [PACK_W-1:0] p, int slot);
            logic signed [COORD_BITS-1:0] c;
            c = p[slot*COORD_BITS +: COORD_BITS];
            return longint'(c);
        endfunction

        static function longint sat_coord(longint v);
            longint hi;
            hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        static function longint root_floor(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        // Arithmetic right shift by 15 with halves rounded away from zero.
        static function longint round_q15(longint x);
            if (x < 0) return -((-x + (longint'(1) <<< 14)) >>> 15);
            return (x + (longint'(1) <<< 14)) >>> 15;
        endfunction

        function void note_pair(pair_t p);
            longint   od[3], nd[3], nrm[3];
            longint   odsq, ndsq, closest, radsum, thr, odist, depth, scale;
            longint   mag, q, wp, ra, rb;
            contact_t c;
            pairs_seen++;
            odsq = 0;
            ndsq = 0;
            for (int k = 0; k < 3; k++)
            begin
                od[k] = coord(p.old_center_a, k) - coord(p.old_center_b, k);
                nd[k] = coord(p.new_center_a, k) - coord(p.new_center_b, k);
                odsq += od[k] * od[k];
                ndsq += nd[k] * nd[k];
            end
            closest = (odsq < ndsq) ? odsq : ndsq;
            radsum  = longint'(p.new_radius_a) + longint'(p.new_radius_b);
            thr     = radsum + tol_q;
            if (!(closest < thr * thr))
                return;

            odist = root_floor(odsq);
            depth = radsum - odist;
            if (odist > min_dist_q && odist != 0)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    mag = (od[k] < 0) ? -od[k] : od[k];
                    q   = ((mag <<< NORM_FRAC) + (odist >>> 1)) / odist;
                    if (od[k] < 0) q = -q;
                    if (q > 32767) q = 32767;
                    if (q < -32768) q = -32768;
                    nrm[k] = q;
                    c.contact_normal[k*NORM_W +: NORM_W] = q[NORM_W-1:0];
                end
            end
            else
            begin
                fallback_used++;
                c.contact_normal = fb_normal;
                for (int k = 0; k < 3; k++)
                    nrm[k] = longint'($signed(fb_normal[k*NORM_W +: NORM_W]));
            end

            // Offset from B's old centre, held in one extra fraction bit.
            scale = 2 * longint'(p.old_radius_b) - depth;
            for (int k = 0; k < 3; k++)
            begin
                wp = coord(p.old_center_b, k) + round_q15(scale * nrm[k]);
                ra = sat_coord(wp - coord(p.body_pos_a, k));
                rb = sat_coord(wp - coord(p.body_pos_b, k));
                c.contact_rel_a[k*COORD_BITS +: COORD_BITS] = ra[COORD_BITS-1:0];
                c.contact_rel_b[k*COORD_BITS +: COORD_BITS] = rb[COORD_BITS-1:0];
            end
            if (depth > 2097151) depth = 2097151;
            if (depth < -2097152) depth = -2097152;
            c.depth      = depth[DEPTH_W-1:0];
            c.result_tag = p.pair_tag;
            pending.push_back(c);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function void check_result(contact_t got);
            contact_t want;
            if (pending.size() == 0)
            begin
                flag($sformatf("unexpected contact beat, tag %h", got.result_tag));
                return;
            end
            want = pending.pop_front();
            contacts_seen++;
            if (got.contact_normal !== want.contact_normal)
                flag($sformatf("tag %h normal exp %h got %h", want.result_tag,
                               want.contact_normal, got.contact_normal));
            if (got.contact_rel_a !== want.contact_rel_a)
                flag($sformatf("tag %h rel_a exp %h got %h", want.result_tag,
                               want.contact_rel_a, got.contact_rel_a));
            if (got.contact_rel_b !== want.contact_rel_b)
                flag($sformatf("tag %h rel_b exp %h got %h", want.result_tag,
                               want.contact_rel_b, got.contact_rel_b));
            if (got.depth !== want.depth)
                flag($sformatf("tag %h depth exp %h got %h", want.result_tag,
                               want.depth, got.depth));
            if (got.result_tag !== want.result_tag)
                flag($sformatf("tag exp %h got %h", want.result_tag, got.result_tag));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    spc_in_if  pair_if();
    spc_out_if contact_if();
    spc_cfg_if cfg_if();

    sphere_pair_contact i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pair_in     (pair_if),
        .contact_out (contact_if),
        .cfg         (cfg_if)
    );

    contact_board board;
    bit           no_idle;
    int           out_hold;
    int           quiet_cycles;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // All beats are observed at the rising edge, before the block updates.
    always @(posedge clk)
    begin
        contact_t got;
        if (rst_n && contact_if.valid && contact_if.ready)
        begin
            got.contact_normal = contact_if.contact_normal;
            got.contact_rel_a  = contact_if.contact_rel_a;
            got.contact_rel_b  = contact_if.contact_rel_b;
            got.depth          = contact_if.depth;
            got.result_tag     = contact_if.result_tag;
            board.check_result(got);
            out_hold = no_idle ? 0 : $urandom_range(0, 3);
        end
        if ((pair_if.valid && pair_if.ready) || (contact_if.valid && contact_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles", HANG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // The receiver stalls for a drawn number of cycles after each result beat.
    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            contact_if.ready <= 1'b0;
            out_hold--;
        end
        else
            contact_if.ready <= 1'b1;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        cfg_if.valid <= 1'b1;
        do @(posedge clk); while (!cfg_if.ready);
        board.note_reg_write(idx, data);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Holds the pair until it is taken, then idles for a drawn gap.
    task automatic send_pair(pair_t p);
        int gap;
        @(negedge clk);
        pair_if.old_center_a <= p.old_center_a;
        pair_if.new_center_a <= p.new_center_a;
        pair_if.old_center_b <= p.old_center_b;
        pair_if.new_center_b <= p.new_center_b;
        pair_if.new_radius_a <= p.new_radius_a;
        pair_if.new_radius_b <= p.new_radius_b;
        pair_if.old_radius_b <= p.old_radius_b;
        pair_if.body_pos_a   <= p.body_pos_a;
        pair_if.body_pos_b   <= p.body_pos_b;
        pair_if.pair_tag     <= p.pair_tag;
        pair_if.valid        <= 1'b1;
        do @(posedge clk); while (!pair_if.ready);
        board.note_pair(p);
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            @(negedge clk);
            pair_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stops offering pairs, waits for every expected contact, then lets pairs
    // without contact clear.
    task automatic drain();
        @(negedge clk);
        pair_if.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [PACK_W-1:0] pack3(int x, int y, int z);
        return {x[COORD_BITS-1:0], y[COORD_BITS-1:0], z[COORD_BITS-1:0]};
    endfunction

    function automatic logic [PACK_W-1:0] wild_triple();
        return {$urandom, $urandom};
    endfunction

    function automatic int jitter(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Most pairs sit near touching distance with random content; some are
    // pure noise, some approach from far away so that the old distance is large.
    function automatic pair_t random_pair();
        pair_t p;
        int    span, bx, by, bz, dx, dy, dz, mode;
        mode = $urandom_range(0, 9);
        span = 1 << $urandom_range(2, 19);
        bx = jitter(1 << 19);
        by = jitter(1 << 19);
        bz = jitter(1 << 19);
        dx = jitter(span);
        dy = jitter(span);
        dz = jitter(span);
        p.new_radius_a = $urandom_range(0, span);
        p.new_radius_b = $urandom_range(0, span);
        p.old_radius_b = ($urandom_range(0, 3) == 0) ? RAD_W'($urandom)
                                                     : p.new_radius_b + jitter(span / 8 + 1);
        p.old_center_b = pack3(bx, by, bz);
        p.old_center_a = pack3(bx + dx, by + dy, bz + dz);
        p.new_center_b = pack3(bx + jitter(span / 4), by + jitter(span / 4),
                               bz + jitter(span / 4));
        p.new_center_a = pack3(bx + dx + jitter(span / 4), by + dy + jitter(span / 4),
                               bz + dz + jitter(span / 4));
        if (mode == 0)
        begin
            p.old_center_a = wild_triple();
            p.new_center_a = wild_triple();
            p.old_center_b = wild_triple();
            p.new_center_b = wild_triple();
            p.new_radius_a = RAD_W'($urandom);
            p.new_radius_b = RAD_W'($urandom);
        end
        else if (mode == 1)
            p.old_center_a = wild_triple();
        else if (mode == 2)
            p.old_center_a = p.old_center_b;
        p.body_pos_a = ($urandom_range(0, 3) == 0) ? '0 : wild_triple();
        p.body_pos_b = ($urandom_range(0, 3) == 0) ? '0 : wild_triple();
        p.pair_tag   = TAG_W'($urandom);
        return p;
    endfunction

    function automatic pair_t plain_pair(logic [PACK_W-1:0] oa, logic [PACK_W-1:0] ob,
                                         logic [RAD_W-1:0] rad, logic [TAG_W-1:0] tag);
        pair_t p;
        p.old_center_a = oa;
        p.new_center_a = oa;
        p.old_center_b = ob;
        p.new_center_b = ob;
        p.new_radius_a = rad;
        p.new_radius_b = rad;
        p.old_radius_b = rad;
        p.body_pos_a   = '0;
        p.body_pos_b   = '0;
        p.pair_tag     = tag;
        return p;
    endfunction

    task automatic directed_pairs();
        pair_t p;
        int    lo, hi;
        lo = -(1 << 20);
        hi = (1 << 20) - 1;
        // All zero: threshold is zero, so no contact.
        send_pair(plain_pair('0, '0, '0, 16'h0000));
        // Coincident centres with radius: fallback normal.
        send_pair(plain_pair(pack3(5, -7, 9), pack3(5, -7, 9), 20'd300, 16'hFFFF));
        // Distance exactly at and just above the minimum distance.
        send_pair(plain_pair(pack3(1, 0, 0), pack3(0, 0, 0), 20'd100, 16'h0001));
        send_pair(plain_pair(pack3(2, 0, 0), pack3(0, 0, 0), 20'd100, 16'h0002));
        // Single-axis deltas of each sign on each axis.
        for (int k = 0; k < 3; k++)
        begin
            send_pair(plain_pair(pack3(k == 0 ? 900 : 0, k == 1 ? 900 : 0, k == 2 ? 900 : 0),
                                 '0, 20'd1024, 16'h0010 + k));
            send_pair(plain_pair(pack3(k == 0 ? -900 : 0, k == 1 ? -900 : 0,
                                       k == 2 ? -900 : 0), '0, 20'd1024, 16'h0020 + k));
        end
        // Coordinate extremes with the largest radii.
        send_pair(plain_pair(pack3(hi, hi, hi), pack3(lo, lo, lo), '1, 16'h8000));
        send_pair(plain_pair(pack3(lo, hi, lo), pack3(hi, lo, hi), '1, 16'h7FFF));
        send_pair(plain_pair(pack3(hi, hi, hi), pack3(hi - 10, hi, hi), '1, 16'h1234));
        // All ones in every field.
        p = plain_pair('1, '1, '1, '1);
        p.body_pos_a = '1;
        p.body_pos_b = '1;
        send_pair(p);
        // Far apart at the old position, touching at the new one: deep negative depth.
        p = plain_pair(pack3(hi, hi, hi), pack3(lo, lo, lo), 20'd50, 16'h0BAD);
        p.new_center_a = pack3(0, 0, 10);
        p.new_center_b = pack3(0, 0, 0);
        send_pair(p);
        // Contact point far from the bodies, so relative positions saturate.
        p = plain_pair(pack3(hi, hi, hi), pack3(hi - 20, hi, hi), '1, 16'h5A5A);
        p.body_pos_a = pack3(lo, lo, lo);
        p.body_pos_b = pack3(hi, lo, hi);
        send_pair(p);
        // Zero radii just separated, then just touching with old radius zero.
        send_pair(plain_pair(pack3(0, 3, 0), '0, '0, 16'h00A0));
        p = plain_pair(pack3(0, 0, 40), '0, 20'd21, 16'h00A1);
        p.old_radius_b = '0;
        send_pair(p);
    endtask

    task automatic random_pairs(int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_pair(random_pair());
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        board        = new();
        no_idle      = 1'b0;
        out_hold     = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        pair_if.valid        = 1'b0;
        pair_if.old_center_a = '0;
        pair_if.new_center_a = '0;
        pair_if.old_center_b = '0;
        pair_if.new_center_b = '0;
        pair_if.new_radius_a = '0;
        pair_if.new_radius_b = '0;
        pair_if.old_radius_b = '0;
        pair_if.body_pos_a   = '0;
        pair_if.body_pos_b   = '0;
        pair_if.pair_tag     = '0;
        contact_if.ready     = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_TOLERANCE;
        cfg_if.data          = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Reset register values first, with the directed pairs.
        directed_pairs();
        random_pairs(PHASE_ITEMS - 20);
        drain();

        // Largest tolerance, smallest minimum distance, random fallback.
        write_reg(CFG_TOLERANCE, {$urandom, $urandom} | 48'hFFFFF);
        write_reg(CFG_MIN_DIST, {$urandom, $urandom} & ~48'hFFFFF);
        write_reg(CFG_FALLBACK, {$urandom, $urandom});
        random_pairs(PHASE_ITEMS);
        drain();

        // No tolerance, largest minimum distance: every contact whose old distance is at most that takes the fallback.
        write_reg(CFG_TOLERANCE, {$urandom, $urandom} & ~48'hFFFFF);
        write_reg(CFG_MIN_DIST, 48'hFFFFF);
        write_reg(CFG_FALLBACK, '1);
        random_pairs(PHASE_ITEMS);
        drain();

        write_reg(CFG_TOLERANCE, $urandom_range(0, 4096));
        write_reg(CFG_MIN_DIST, $urandom_range(0, 64));
        write_reg(CFG_FALLBACK, 48'h4000_0000_0000);
        random_pairs(PHASE_ITEMS);
        drain();

        write_reg(CFG_TOLERANCE, '0);
        write_reg(CFG_MIN_DIST, 48'd1);
        write_reg(CFG_FALLBACK, '0);
        random_pairs(PHASE_ITEMS);
        drain();

        write_reg(CFG_TOLERANCE, {$urandom, $urandom});
        write_reg(CFG_MIN_DIST, {$urandom, $urandom});
        write_reg(CFG_FALLBACK, {$urandom, $urandom});
        random_pairs(PHASE_ITEMS);
        drain();

        $display("Covered %0d pairs, %0d contacts (%0d on the fallback normal), %0d writes.",
                 board.pairs_seen, board.contacts_seen, board.fallback_used, board.reg_writes);
        $display("Mismatches: %0d, contacts still outstanding: %0d.",
                 board.mismatches, board.pending.size());
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
